### sv/lcs_all_substrings_macros.svh
// Assertion macros for the lcs_all_substrings RTL.
// Needs nothing else; files that assert include it by name.
`ifndef LCS_ALL_SUBSTRINGS_MACROS_SVH
`define LCS_ALL_SUBSTRINGS_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define LCS_CHECK(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcs check failed");

// Next-cycle implication, switched off during reset.
`define LCS_CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcs next-cycle check failed");

`endif

### sv/lcs_pkg.sv
// Shared types and constants for the lcs_all_substrings block.
// No dependencies; every RTL file of the block imports it.
package lcs_pkg;

  localparam int LCS_REF_MAX  = 64;
  localparam int LCS_TEXT_MAX = 64;
  localparam int SYM_W        = 8;
  localparam int IDX_W        = 6;
  localparam int LEN_W        = 7;

  typedef enum logic [1:0] {
    OP_CLEAR       = 2'd0,
    OP_APPEND_REF  = 2'd1,
    OP_APPEND_TEXT = 2'd2,
    OP_QUERY       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_BAD
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] row_start;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] end_index;
    logic [LEN_W-1:0] lcs_length;
    logic             bad_query;
    logic             overflowed;
    logic             last;
  } result_t;

  // One text symbol travelling along the chain with the row value to its left.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] left;
    logic [IDX_W-1:0] end_index;
    logic             last;
  } token_t;

  typedef struct packed {
    logic adv;
    logic clear_rows;
    logic clear_ref;
    logic write;
  } cell_ctrl_t;

endpackage

### sv/lcs_cell.sv
// One cell of the LCS chain: holds one reference symbol and its row entry.
// Depends on lcs_pkg.
module lcs_cell import lcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [SYM_W-1:0] wr_sym,
  input  token_t           tin,
  output token_t           tout
);

  logic             active;
  logic [SYM_W-1:0] ref_sym;
  logic [LEN_W-1:0] dp;
  logic [LEN_W-1:0] prev_left;
  logic [LEN_W-1:0] dp_next;

  // Row entry for this text symbol: diagonal plus one on a match, else the larger neighbour.
  always_comb begin
    if (tin.symbol == ref_sym) begin
      dp_next = prev_left + LEN_W'(1);
    end else if (tin.left > dp) begin
      dp_next = tin.left;
    end else begin
      dp_next = dp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.clear_ref) begin
      active <= 1'b0;
    end else if (ctrl.write) begin
      active <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      ref_sym <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear_rows) begin
      dp        <= '0;
      prev_left <= '0;
    end else if (ctrl.adv && tin.valid && active) begin
      dp        <= dp_next;
      prev_left <= tin.left;
    end
  end

  // An inactive cell lies past the reference and forwards the row value untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (ctrl.adv) begin
      tout.valid     <= tin.valid;
      tout.symbol    <= tin.symbol;
      tout.end_index <= tin.end_index;
      tout.last      <= tin.last;
      tout.left      <= active ? dp_next : tin.left;
    end
  end

endmodule

### sv/lcs_chain.sv
// Row of LCS cells, one per reference position, with the append decode.
// Depends on lcs_pkg and lcs_cell.
module lcs_chain import lcs_pkg::*; #(
  parameter  int REF_MAX = LCS_REF_MAX,
  localparam int RC_W    = $clog2(REF_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [RC_W-1:0]  wr_addr,
  input  logic [SYM_W-1:0] wr_sym,
  input  token_t           tok_in,
  output token_t           tok_out
);

  token_t tok [REF_MAX+1];

  assign tok[0]  = tok_in;
  assign tok_out = tok[REF_MAX];

  for (genvar i = 0; i < REF_MAX; i++) begin : g_cell
    cell_ctrl_t cc;

    always_comb begin
      cc       = ctrl;
      cc.write = ctrl.write && (wr_addr == RC_W'(i));
    end

    lcs_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cc),
      .wr_sym (wr_sym),
      .tin    (tok[i]),
      .tout   (tok[i+1])
    );
  end

endmodule

### sv/lcs_all_substrings.sv
// Results pass through the feed register, the cell chain and the output register.
// A good query with n results gives one result per cycle once the chain is full,
// while the receiver does not stall; the cell chain depth sets the fill time.
// A bad start's single result passes the ST_BAD state and the output register.
// Reset (rst, synchronous, active high) empties both strings, the overflow flag,
// the chain and the output register; the stores themselves are not cleared.
// Depends on lcs_pkg, lcs_chain and lcs_all_substrings_macros.svh.
`include "lcs_all_substrings_macros.svh"

module lcs_all_substrings import lcs_pkg::*; #(
  parameter int REF_MAX  = LCS_REF_MAX,
  parameter int TEXT_MAX = LCS_TEXT_MAX
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int RC_W = $clog2(REF_MAX + 1);
  localparam int TC_W = $clog2(TEXT_MAX + 1);
  localparam int TA_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

  // The text lives in a small memory; the reference lives in the cells themselves.
  logic [SYM_W-1:0] text_mem [TEXT_MAX];

  logic [RC_W-1:0]  ref_count;
  logic [TC_W-1:0]  text_count;
  logic             overflow_flag;
  logic [TC_W-1:0]  ptr;
  logic [TC_W-1:0]  ptr_inc;
  logic [IDX_W-1:0] row_start_q;

  state_e state, state_next;

  logic       item_xfer;
  logic       adv;
  logic       feeding;
  logic       bad_load;
  logic       start_bad;
  logic       ref_room;
  logic       text_room;
  logic       feed_last;
  token_t     feed;
  token_t     chain_out;
  cell_ctrl_t chain_ctrl;

  assign item_xfer = item_valid && !item_stall;

  // The whole chain moves only when the output register can take a new value.
  assign adv = !result_valid || !result_stall;

  assign ref_room  = ref_count < RC_W'(REF_MAX);
  assign text_room = text_count < TC_W'(TEXT_MAX);
  assign ptr_inc   = ptr + TC_W'(1);
  assign feed_last = ptr_inc == text_count;

  // A start index at or beyond the loaded text, an empty text included, is a bad query.
  assign start_bad = {1'b0, item.row_start} >= (IDX_W + 1)'(text_count);

  // Next-state logic of the query sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_xfer && item.operation == OP_QUERY) begin
          state_next = start_bad ? ST_BAD : ST_FEED;
        end
      end
      ST_FEED: begin
        if (adv && feed_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv && chain_out.valid && chain_out.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: new items are taken only between queries.
  always_comb begin
    item_stall = 1'b1;
    feeding    = 1'b0;
    bad_load   = 1'b0;
    case (state)
      ST_IDLE:  item_stall = 1'b0;
      ST_FEED:  feeding    = 1'b1;
      ST_DRAIN: item_stall = 1'b1;
      ST_BAD:   bad_load   = 1'b1;
      default:  item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // String counts and the overflow flag, which stays set until the next clear or reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count     <= '0;
      text_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (item_xfer) begin
      case (item.operation)
        OP_CLEAR: begin
          ref_count     <= '0;
          text_count    <= '0;
          overflow_flag <= 1'b0;
        end
        OP_APPEND_REF: begin
          if (ref_room) begin
            ref_count <= ref_count + RC_W'(1);
          end else begin
            overflow_flag <= 1'b1;
          end
        end
        OP_APPEND_TEXT: begin
          if (text_room) begin
            text_count <= text_count + TC_W'(1);
          end else begin
            overflow_flag <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer && item.operation == OP_APPEND_TEXT && text_room) begin
      text_mem[text_count[TA_W-1:0]] <= item.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer && item.operation == OP_QUERY) begin
      row_start_q <= item.row_start;
    end
  end

  // The read pointer walks from the start index to the end of the text.
  always_ff @(posedge clk) begin
    if (item_xfer && item.operation == OP_QUERY) begin
      ptr <= TC_W'(item.row_start);
    end else if (feeding && adv) begin
      ptr <= ptr_inc;
    end
  end

  // Feed register: the registered text read that enters the first cell.
  // The row value left of the first cell is always zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed.valid <= 1'b0;
      feed.left  <= '0;
    end else if (adv) begin
      feed.valid <= feeding;
      if (feeding) begin
        feed.symbol    <= text_mem[ptr[TA_W-1:0]];
        feed.end_index <= IDX_W'(ptr);
        feed.last      <= feed_last;
      end
    end
  end

  // A query transfer zeroes every row entry; the chain is empty at that point.
  always_comb begin
    chain_ctrl.adv        = adv;
    chain_ctrl.clear_rows = item_xfer && item.operation == OP_QUERY;
    chain_ctrl.clear_ref  = item_xfer && item.operation == OP_CLEAR;
    chain_ctrl.write      = item_xfer && item.operation == OP_APPEND_REF && ref_room;
  end

  lcs_chain #(
    .REF_MAX (REF_MAX)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (chain_ctrl),
    .wr_addr (ref_count),
    .wr_sym  (item.symbol),
    .tok_in  (feed),
    .tok_out (chain_out)
  );

  // Output register: takes either the token leaving the chain or the bad-query result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= chain_out.valid || bad_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (bad_load) begin
        result.end_index  <= row_start_q;
        result.lcs_length <= '0;
        result.bad_query  <= 1'b1;
        result.overflowed <= overflow_flag;
        result.last       <= 1'b1;
      end else begin
        result.end_index  <= chain_out.end_index;
        result.lcs_length <= chain_out.left;
        result.bad_query  <= 1'b0;
        result.overflowed <= overflow_flag;
        result.last       <= chain_out.last;
      end
    end
  end

  `LCS_CHECK(a_text_count_bound, clk, rst, 1'b1, text_count <= TC_W'(TEXT_MAX))
  `LCS_CHECK(a_tokens_only_in_query, clk, rst, chain_out.valid,
             state == ST_FEED || state == ST_DRAIN)
  `LCS_CHECK(a_bad_chain_empty, clk, rst, state == ST_BAD, !chain_out.valid && !feed.valid)
  `LCS_CHECK_NEXT(a_results_contiguous, clk, rst,
                  result_valid && !result_stall && !result.last, result_valid)

endmodule

### sim/testbench.sv
// Self-checking testbench for lcs_all_substrings: drives clears, appends and queries,
// predicts every result with its own dynamic-programming sweep and checks each transfer.
// Depends on lcs_pkg and the lcs_all_substrings RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // When set, neither the sender nor the receiver inserts any idle cycles.
  bit no_idling = 1'b0;

  int mismatches = 0;
  int checked = 0;
  int sent = 0;

  // Our own copy of the block's strings, counts and overflow flag.
  logic [SYM_W-1:0] ref_syms [LCS_REF_MAX];
  logic [SYM_W-1:0] text_syms [LCS_TEXT_MAX];
  int               ref_len = 0;
  int               text_len = 0;
  logic             dropped = 1'b0;

  // Results that the predictor has worked out and the block has not yet delivered.
  result_t pending_results [$];

  lcs_all_substrings dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Safety net: the slowest correct run is far shorter than this.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Updates the model with one accepted transfer and, for a query, queues every
  // result it must produce. A query sweeps text[l..] against the whole reference,
  // keeping one row of LCS lengths indexed by reference position.
  function automatic void predict_lcs_results(item_t it);
    logic [LEN_W-1:0] row [LCS_REF_MAX + 1];
    logic [LEN_W-1:0] diag, up, nv;
    result_t          res;
    case (it.operation)
      OP_CLEAR: begin
        ref_len = 0;
        text_len = 0;
        dropped = 1'b0;
      end
      OP_APPEND_REF: begin
        if (ref_len < LCS_REF_MAX) begin
          ref_syms[ref_len] = it.symbol;
          ref_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_APPEND_TEXT: begin
        if (text_len < LCS_TEXT_MAX) begin
          text_syms[text_len] = it.symbol;
          text_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_QUERY: begin
        if (int'(it.row_start) >= text_len) begin
          // A start outside the loaded text gives one flagged result only.
          res.end_index  = it.row_start;
          res.lcs_length = '0;
          res.bad_query  = 1'b1;
          res.overflowed = dropped;
          res.last       = 1'b1;
          pending_results.push_back(res);
        end else begin
          for (int j = 0; j <= LCS_REF_MAX; j++) row[j] = '0;
          for (int r = int'(it.row_start); r < text_len; r++) begin
            diag = '0;
            for (int j = 1; j <= ref_len; j++) begin
              up = row[j];
              if (text_syms[r] == ref_syms[j-1]) begin
                nv = diag + 1'b1;
              end else begin
                nv = (row[j-1] > up) ? row[j-1] : up;
              end
              diag = up;
              row[j] = nv;
            end
            res.end_index  = IDX_W'(r);
            res.lcs_length = row[ref_len];
            res.bad_query  = 1'b0;
            res.overflowed = dropped;
            res.last       = (r + 1 == text_len);
            pending_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $realtime, checked, msg);
    mismatches++;
  endtask

  // Receiver: stalls at random, except in the stretch where idling is switched off.
  always @(posedge clk) begin
    result_stall <= !no_idling && ($urandom_range(99) < 13);
  end

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, end_index %0d", result.end_index));
      end else begin
        want = pending_results.pop_front();
        if (result.end_index !== want.end_index)
          report_mismatch($sformatf("end_index expected %0d, got %0d",
                                    want.end_index, result.end_index));
        if (result.lcs_length !== want.lcs_length)
          report_mismatch($sformatf("lcs_length expected %0d, got %0d",
                                    want.lcs_length, result.lcs_length));
        if (result.bad_query !== want.bad_query)
          report_mismatch($sformatf("bad_query expected %0b, got %0b",
                                    want.bad_query, result.bad_query));
        if (result.overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed expected %0b, got %0b",
                                    want.overflowed, result.overflowed));
        if (result.last !== want.last)
          report_mismatch($sformatf("last expected %0b, got %0b", want.last, result.last));
      end
      checked++;
    end
  end

  // Sends one item. Valid is left high on return so that a following item can
  // go out back to back; anything that waits afterwards lowers it first.
  task automatic send_item(item_t it);
    while (!no_idling && $urandom_range(99) < 13) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_lcs_results(it);
    sent++;
  endtask

  task automatic clear_strings();
    send_item('{operation: OP_CLEAR, symbol: SYM_W'($urandom), row_start: IDX_W'($urandom)});
  endtask

  task automatic append_ref(logic [SYM_W-1:0] sym);
    send_item('{operation: OP_APPEND_REF, symbol: sym, row_start: IDX_W'($urandom)});
  endtask

  task automatic append_text(logic [SYM_W-1:0] sym);
    send_item('{operation: OP_APPEND_TEXT, symbol: sym, row_start: IDX_W'($urandom)});
  endtask

  task automatic query(int start);
    send_item('{operation: OP_QUERY, symbol: SYM_W'($urandom), row_start: IDX_W'(start)});
  endtask

  // Holds the sender off until every predicted result has been delivered.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Straight after reset both strings are empty, so any start is out of range.
  task automatic test_bad_start_on_empty();
    query(0);
    query(63);
  endtask

  // Symbols at both ends of their range, a full sweep, a sweep of one result,
  // and starts just past and far past the end of the text.
  task automatic test_extreme_symbols();
    append_ref(8'h00);
    append_ref(8'hFF);
    append_ref(8'hA5);
    append_text(8'hFF);
    append_text(8'h00);
    append_text(8'h5A);
    append_text(8'hA5);
    query(0);
    query(3);
    query(4);
    query(63);
  endtask

  // With no reference loaded every length must come back as zero.
  task automatic test_empty_reference();
    clear_strings();
    append_text(8'h11);
    append_text(8'hEE);
    append_text(8'h11);
    query(0);
    query(1);
    clear_strings();
    query(0);
  endtask

  // Fills both stores and pushes one symbol past each, so the overflow flag
  // shows on a flagged result and on a full sweep. Text equal to the reference
  // drives the length to its maximum. A clear must then drop the flag.
  task automatic test_overflow();
    logic [SYM_W-1:0] syms [LCS_REF_MAX];
    clear_strings();
    for (int i = 0; i < LCS_REF_MAX; i++) begin
      syms[i] = SYM_W'($urandom);
      append_ref(syms[i]);
    end
    append_ref(SYM_W'($urandom));
    query($urandom_range(63));
    for (int i = 0; i < LCS_TEXT_MAX; i++) append_text(syms[i]);
    append_text(SYM_W'($urandom));
    query(0);
    query(63);
    drain_results();
    clear_strings();
    query($urandom_range(63));
  endtask

  // One well-formed load-and-query sequence with random content. Small alphabets
  // make matches common; now and then the clear is left out so strings build up.
  task automatic random_session();
    int nref, ntext, nq, alpha, base;
    alpha = ($urandom_range(7) == 0) ? 256 : $urandom_range(4, 2);
    base  = $urandom_range(256 - alpha);
    nref  = ($urandom_range(7) == 0) ? $urandom_range(64, 20) : $urandom_range(6);
    ntext = ($urandom_range(7) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
    if ($urandom_range(5) != 0) clear_strings();
    while (nref > 0 || ntext > 0) begin
      if (nref > 0 && (ntext == 0 || $urandom_range(1) == 0)) begin
        append_ref(SYM_W'(base + $urandom_range(alpha - 1)));
        nref--;
      end else begin
        append_text(SYM_W'(base + $urandom_range(alpha - 1)));
        ntext--;
      end
    end
    nq = $urandom_range(3, 1);
    repeat (nq) begin
      if ($urandom_range(9) != 0 && text_len > 0) query($urandom_range(text_len - 1));
      else query($urandom_range(63));
    end
  endtask

  // Mostly whole sequences, with stray items of any kind mixed in, and now and
  // then a pause until everything outstanding has come back.
  task automatic test_random_sessions();
    int first;
    first = sent;
    while (sent - first < 40) begin
      if ($urandom_range(4) == 0) begin
        send_item('{operation: op_e'($urandom_range(3)), symbol: SYM_W'($urandom),
                    row_start: IDX_W'($urandom)});
      end else begin
        random_session();
      end
      if ($urandom_range(5) == 0) drain_results();
    end
  endtask

  // A stretch with no idling on either side, so transfers run back to back.
  task automatic test_back_to_back();
    drain_results();
    no_idling = 1'b1;
    repeat (2) random_session();
    drain_results();
    no_idling = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_bad_start_on_empty();
    test_extreme_symbols();
    test_empty_reference();
    test_overflow();
    test_random_sessions();
    test_back_to_back();
    // Let everything drain, then allow one more chain fill for stray results.
    drain_results();
    repeat (LCS_REF_MAX + 8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
